/* sv/pcs_pkg.sv */
package pcs_pkg;

	// fixed field widths
	localparam int unsigned SCORE_W    = 36;
	localparam int unsigned VISITS_W   = 20;
	localparam int unsigned PRIOR_W    = 17;
	localparam int unsigned WEIGHT_W   = 16;
	localparam int unsigned INDEX_W    = 6;
	localparam int unsigned DIVISOR_W  = VISITS_W + 1;
	localparam int unsigned WEIGHT_FRAC = 12;
	localparam int unsigned CP_W       = WEIGHT_W + PRIOR_W;

	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd4096;

	// defaults for the top-level parameters
	localparam int unsigned MAX_CHILDREN_DEF  = 64;
	localparam int unsigned FRACTION_BITS_DEF = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WIN,
		ST_MUL1,
		ST_MUL2,
		ST_DIVS,
		ST_DIVE
	} pcs_state_t;

endpackage

/* sv/pcs_div.sv */
module pcs_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pcs_pkg::SCORE_W-1:0]    dividend,
	input  logic [pcs_pkg::DIVISOR_W-1:0]  divisor,
	output logic                           busy,
	output logic [pcs_pkg::SCORE_W-1:0]    quotient
);
	import pcs_pkg::*;

	localparam int unsigned CW = $clog2(SCORE_W + 1);

	logic [SCORE_W-1:0]   nq_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] divisor_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;

	logic [DIVISOR_W:0]   rem_sh;
	logic                 q_bit;
	logic [DIVISOR_W:0]   rem_sub;

	// one quotient bit per cycle: shift the dividend out, the quotient in
	always_comb begin
		rem_sh  = {rem_q, nq_q[SCORE_W-1]};
		q_bit   = rem_sh >= {1'b0, divisor_q};
		rem_sub = rem_sh - {1'b0, divisor_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(SCORE_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q      <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			nq_q  <= {nq_q[SCORE_W-2:0], q_bit};
			rem_q <= q_bit ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = nq_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q) else $error("divider did not go busy");
	a_fell_count: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(cnt_q) == CW'(1)) else $error("divider ended early");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !$past(start) && divisor_q != '0 |-> rem_q < divisor_q)
		else $error("remainder not below divisor");

endmodule

/* sv/pcs_sqrt.sv */
module pcs_sqrt #(
	parameter int unsigned RW = 26
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [2*RW-1:0] radicand,
	output logic            busy,
	output logic [RW-1:0]   root
);
	import pcs_pkg::*;

	localparam int unsigned CW = $clog2(RW + 1);

	logic [2*RW-1:0] rad_q;
	logic [RW:0]     rem_q;
	logic [RW-1:0]   root_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q;

	logic [RW+2:0]   rem_sh;
	logic [RW+2:0]   trial;
	logic            take;
	logic [RW+2:0]   rem_sub;

	// two radicand bits per cycle, one root bit out
	always_comb begin
		rem_sh  = {rem_q, rad_q[2*RW-1 -: 2]};
		trial   = {1'b0, root_q, 2'b01};
		take    = rem_sh >= trial;
		rem_sub = rem_sh - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			root_q <= '0;
			rem_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(RW);
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			root_q <= {root_q[RW-2:0], take};
			rem_q  <= take ? rem_sub[RW:0] : rem_sh[RW:0];
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
		end else if (busy_q) begin
			rad_q <= {rad_q[2*RW-3:0], 2'b00};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q) else $error("root unit did not go busy");
	a_fell_count: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(cnt_q) == CW'(1)) else $error("root unit ended early");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(RW+2)'(rem_q) <= {1'b0, root_q, 1'b0}) else $error("root remainder too large");

endmodule

/* sv/puct_child_select.sv */
// Channel   Direction  Handshake              Payload
// in        inbound    in_valid / in_stall    child_score, child_visits, child_prior,
//                                             parent_visits, opponent_turn, last_child
// out       outbound   out_valid / out_stall  best_index, best_value
// cfg       inbound    cfg_write_enable       cfg_write_data (exploration weight)
//
// From its acceptance to the next acceptance, one child takes two passes through the shared
// bit-serial divider (win rate, then exploration term).
// The square root of the parent count runs beside the first division of a node.
// Reset clears control state and sets the exploration weight to 1.0.
// in_stall is high while a child is being worked on; a finished result sits in the
// output register and only holds the last child of the next node while out_stall is high.
module puct_child_select #(
	parameter int unsigned MAX_CHILDREN  = pcs_pkg::MAX_CHILDREN_DEF,
	parameter int unsigned FRACTION_BITS = pcs_pkg::FRACTION_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_enable,
	input  logic [pcs_pkg::WEIGHT_W-1:0]   cfg_write_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [pcs_pkg::SCORE_W-1:0]    child_score,
	input  logic [pcs_pkg::VISITS_W-1:0]   child_visits,
	input  logic [pcs_pkg::PRIOR_W-1:0]    child_prior,
	input  logic [pcs_pkg::VISITS_W-1:0]   parent_visits,
	input  logic                           opponent_turn,
	input  logic                           last_child,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [pcs_pkg::INDEX_W-1:0]    best_index,
	output logic [pcs_pkg::SCORE_W-1:0]    best_value
);
	import pcs_pkg::*;

	localparam int unsigned RW     = VISITS_W / 2 + FRACTION_BITS;
	localparam int unsigned PROD_W = CP_W + RW;
	localparam int unsigned SHIFT  = WEIGHT_FRAC + FRACTION_BITS;
	localparam int unsigned EXP_W  = PROD_W - SHIFT;
	localparam int unsigned CW     = $clog2(MAX_CHILDREN);

	localparam logic [SCORE_W-1:0] ONE = SCORE_W'(1) << FRACTION_BITS;

	pcs_state_t state_q, state_d;

	logic [WEIGHT_W-1:0]  weight_q;
	logic [VISITS_W-1:0]  visits_q;
	logic [PRIOR_W-1:0]   prior_q;
	logic                 opp_q;
	logic                 last_q;
	logic [SCORE_W-1:0]   win_q;
	logic [CP_W-1:0]      cp_q;
	logic [PROD_W-1:0]    prod_q;
	logic [SCORE_W-1:0]   best_q;
	logic [CW-1:0]        best_idx_q;
	logic [CW-1:0]        cnt_q;
	logic                 have_cand_q;
	logic                 out_valid_q;
	logic [INDEX_W-1:0]   out_idx_q;
	logic [SCORE_W-1:0]   out_val_q;

	logic                 in_acc;
	logic                 div_start;
	logic                 sq_start;
	logic                 commit;
	logic                 div_busy;
	logic                 sq_busy;
	logic [SCORE_W-1:0]   quot;
	logic [RW-1:0]        root;
	logic [SCORE_W-1:0]   div_dividend;
	logic [DIVISOR_W-1:0] div_divisor;
	logic [2*RW-1:0]      radicand;
	logic [SCORE_W-1:0]   win_flip;
	logic [SCORE_W:0]     sum;
	logic [SCORE_W-1:0]   value;
	logic                 replace;
	logic [SCORE_W-1:0]   new_best;
	logic [CW-1:0]        new_idx;
	logic [CW+INDEX_W-1:0] idx_ext;
	logic                 out_block;

	assign in_acc = in_valid && !in_stall;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		div_start = 1'b0;
		sq_start  = 1'b0;
		commit    = 1'b0;
		out_block = last_q && out_valid_q && out_stall;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					div_start = 1'b1;
					sq_start  = !have_cand_q;
					state_d   = ST_WIN;
				end
			end
			ST_WIN: begin
				if (!div_busy && !sq_busy) begin
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_DIVS;
			ST_DIVS: begin
				div_start = 1'b1;
				state_d   = ST_DIVE;
			end
			ST_DIVE: begin
				if (!div_busy && !out_block) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// divider operands: win rate on acceptance, exploration term later
	always_comb begin
		if (state_q == ST_IDLE) begin
			div_dividend = child_score;
			div_divisor  = (child_visits == '0) ? DIVISOR_W'(1) : DIVISOR_W'(child_visits);
		end else begin
			div_dividend = SCORE_W'(prod_q[PROD_W-1:SHIFT]);
			div_divisor  = DIVISOR_W'(visits_q) + DIVISOR_W'(1);
		end
	end

	assign radicand = {parent_visits, {(2*FRACTION_BITS){1'b0}}};

	pcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (quot)
	);

	pcs_sqrt #(
		.RW (RW)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (radicand),
		.busy     (sq_busy),
		.root     (root)
	);

	always_comb begin
		win_flip = opp_q ? ((quot >= ONE) ? '0 : ONE - quot) : quot;
		sum      = {1'b0, win_q} + (SCORE_W+1)'(quot[EXP_W-1:0]);
		value    = sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];
		replace  = !have_cand_q || (value > best_q);
		new_best = replace ? value : best_q;
		new_idx  = replace ? cnt_q : best_idx_q;
		idx_ext  = {{INDEX_W{1'b0}}, new_idx};
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			visits_q <= child_visits;
			prior_q  <= child_prior;
			opp_q    <= opponent_turn;
			last_q   <= last_child;
		end
		if (state_q == ST_WIN && !div_busy) begin
			win_q <= win_flip;
		end
		if (state_q == ST_MUL1) begin
			cp_q <= CP_W'(weight_q) * CP_W'(prior_q);
		end
		if (state_q == ST_MUL2) begin
			prod_q <= PROD_W'(cp_q) * PROD_W'(root);
		end
		if (commit) begin
			best_q     <= new_best;
			best_idx_q <= new_idx;
		end
		if (commit && last_q) begin
			out_idx_q <= idx_ext[INDEX_W-1:0];
			out_val_q <= new_best;
		end
	end

	// node and output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q    <= WEIGHT_RESET;
			cnt_q       <= '0;
			have_cand_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write_enable) begin
				weight_q <= cfg_write_data;
			end
			if (commit && last_q) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (commit) begin
				if (last_q) begin
					have_cand_q <= 1'b0;
					cnt_q       <= '0;
				end else begin
					have_cand_q <= 1'b1;
					cnt_q       <= (cnt_q == CW'(MAX_CHILDREN - 1)) ? '0 : cnt_q + 1'b1;
				end
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign best_index = out_idx_q;
	assign best_value = out_val_q;

	a_root_on_first: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !have_cand_q |=> sq_busy) else $error("root not started on first child");
	a_node_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		commit && last_q |=> !have_cand_q && cnt_q == '0 && out_valid_q)
		else $error("node state not cleared after result");
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy) else $error("divider restarted while busy");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(out_val_q))
		else $error("pending result overwritten");

endmodule

/* bench/tb_top.sv */
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pcs_pkg::*;

	localparam logic [SCORE_W-1:0]  SCORE_TOP  = 36'd68719411200;
	localparam logic [VISITS_W-1:0] VISITS_TOP = '1;
	localparam logic [PRIOR_W-1:0]  PRIOR_ONE  = 17'd65536;
	localparam int unsigned         FRAC       = FRACTION_BITS_DEF;
	localparam logic [63:0]         VALUE_CEIL = (64'd1 << SCORE_W) - 64'd1;
	localparam logic [63:0]         RATE_ONE   = 64'd1 << FRAC;

	typedef struct packed {
		logic [SCORE_W-1:0]  score;
		logic [VISITS_W-1:0] visits;
		logic [PRIOR_W-1:0]  prior;
		logic [VISITS_W-1:0] parent;
		logic                opp;
		logic                last;
	} child_t;

	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic [SCORE_W-1:0] value;
	} pick_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_write_enable = 1'b0;
	logic [WEIGHT_W-1:0] cfg_write_data = '0;
	logic                in_valid = 1'b0;
	logic [SCORE_W-1:0]  child_score = '0;
	logic [VISITS_W-1:0] child_visits = '0;
	logic [PRIOR_W-1:0]  child_prior = '0;
	logic [VISITS_W-1:0] parent_visits = '0;
	logic                opponent_turn = 1'b0;
	logic                last_child = 1'b0;
	logic                out_stall = 1'b0;
	wire                 in_stall;
	wire                 out_valid;
	wire [INDEX_W-1:0]   best_index;
	wire [SCORE_W-1:0]   best_value;

	// selection state mirrored from the block
	logic [WEIGHT_W-1:0] model_weight = WEIGHT_RESET;
	logic [SCORE_W-1:0]  lead_value = '0;
	logic [INDEX_W-1:0]  lead_index = '0;
	int unsigned         child_pos = 0;
	logic [63:0]         parent_root = '0;
	bit                  node_open = 1'b0;

	pick_t winner_q[$];
	int    fail_cnt = 0;
	int    idle_pct = 0;
	int    stall_pct = 0;
	int    stall_left = 0;

	puct_child_select DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_enable (cfg_write_enable),
		.cfg_write_data   (cfg_write_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.child_score      (child_score),
		.child_visits     (child_visits),
		.child_prior      (child_prior),
		.parent_visits    (parent_visits),
		.opponent_turn    (opponent_turn),
		.last_child       (last_child),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.best_index       (best_index),
		.best_value       (best_value)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#15ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic note_fail(input string msg);
		fail_cnt++;
		if (fail_cnt <= 10) $display("%0t: %s", $time, msg);
	endtask

	function automatic logic [63:0] int_sqrt(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= x) r = t;
		end
		return r;
	endfunction

	function automatic logic [SCORE_W-1:0] puct_value(input child_t c, input logic [63:0] root);
		logic [63:0] win;
		logic [63:0] expl;
		logic [63:0] total;
		win = 64'(c.score) / ((c.visits == '0) ? 64'd1 : 64'(c.visits));
		if (c.opp) win = (win >= RATE_ONE) ? 64'd0 : RATE_ONE - win;
		expl = (64'(model_weight) * 64'(c.prior) * root) / (64'(c.visits) + 64'd1);
		expl = expl >> (WEIGHT_FRAC + FRAC);
		total = win + expl;
		return (total > VALUE_CEIL) ? VALUE_CEIL[SCORE_W-1:0] : total[SCORE_W-1:0];
	endfunction

	task automatic track_child(input child_t c);
		logic [SCORE_W-1:0] v;
		pick_t              w;
		if (!node_open) parent_root = int_sqrt(64'(c.parent) << (2 * FRAC));
		v = puct_value(c, parent_root);
		// first child of a node always takes the lead, later ones must beat it strictly
		if (!node_open || v > lead_value) begin
			lead_value = v;
			lead_index = child_pos[INDEX_W-1:0];
			node_open = 1'b1;
		end
		child_pos = (child_pos + 1 >= MAX_CHILDREN_DEF) ? 0 : child_pos + 1;
		if (c.last) begin
			w.index = lead_index;
			w.value = lead_value;
			winner_q = {winner_q, w};
			node_open = 1'b0;
			child_pos = 0;
		end
	endtask

	task automatic send_child(input child_t c);
		int unsigned gap;
		if ($urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 100);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		child_score   <= c.score;
		child_visits  <= c.visits;
		child_prior   <= c.prior;
		parent_visits <= c.parent;
		opponent_turn <= c.opp;
		last_child    <= c.last;
		do @(posedge clk); while (in_stall);
		track_child(c);
	endtask

	task automatic write_weight(input logic [WEIGHT_W-1:0] w);
		cfg_write_enable <= 1'b1;
		cfg_write_data   <= w;
		@(posedge clk);
		cfg_write_enable <= 1'b0;
		model_weight = w;
	endtask

	// hold off until every expected winner has been taken, then let the block go quiet
	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (winner_q.size() != 0 && guard < 50000) begin
			@(posedge clk);
			guard++;
		end
		repeat (120) @(posedge clk);
	endtask

	function automatic child_t random_child(input logic [VISITS_W-1:0] pv, input logic opp);
		child_t      c;
		logic [63:0] s;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 70) c.visits = VISITS_W'($urandom_range(1, 200));
		else if (pick < 90) c.visits = VISITS_W'($urandom_range(1, 1048575));
		else if (pick < 95) c.visits = '0;
		else c.visits = VISITS_TOP;
		pick = $urandom_range(99);
		if (pick < 75) s = 64'(c.visits) * 64'($urandom_range(0, 65536));
		else if (pick < 85) s = 64'(c.visits) * 64'($urandom_range(65536, 200000));
		else s = {$urandom, $urandom} & VALUE_CEIL;
		if (s > 64'(SCORE_TOP)) s = s % (64'(SCORE_TOP) + 64'd1);
		c.score = s[SCORE_W-1:0];
		pick = $urandom_range(99);
		if (pick < 10) c.prior = PRIOR_ONE;
		else if (pick < 20) c.prior = '0;
		else c.prior = PRIOR_W'($urandom_range(0, 65536));
		c.parent = pv;
		c.opp = opp;
		c.last = 1'b0;
		return c;
	endfunction

	function automatic logic [VISITS_W-1:0] random_parent();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 10) return '0;
		if (pick < 20) return VISITS_TOP;
		if (pick < 60) return VISITS_W'($urandom_range(1, 5000));
		return VISITS_W'($urandom_range(0, 1048575));
	endfunction

	task automatic run_nodes(input int unsigned budget);
		int unsigned sent;
		int unsigned len;
		int unsigned pick;
		logic [VISITS_W-1:0] pv;
		logic opp;
		child_t c;
		child_t prev;
		sent = 0;
		prev = '0;
		while (sent < budget) begin
			pick = $urandom_range(99);
			len = (pick < 85) ? $urandom_range(1, 6) :
				(pick < 97) ? $urandom_range(7, 20) : $urandom_range(60, 70);
			pv = random_parent();
			opp = 1'($urandom_range(1));
			for (int k = 0; k < len; k++) begin
				// parent count on later children should be ignored, so vary it now and then
				c = random_child((k > 0 && $urandom_range(3) == 0) ? random_parent() : pv,
					($urandom_range(9) == 0) ? ~opp : opp);
				if (k > 0 && $urandom_range(9) == 0) begin
					c.score = prev.score;
					c.visits = prev.visits;
					c.prior = prev.prior;
					c.opp = prev.opp;
				end
				c.last = (k == len - 1);
				send_child(c);
				prev = c;
				sent++;
			end
		end
	endtask

	task automatic test_extremes();
		send_child('{score: '0, visits: 1, prior: '0, parent: '0, opp: 0, last: 1});
		send_child('{score: SCORE_TOP, visits: 1, prior: PRIOR_ONE, parent: VISITS_TOP,
			opp: 0, last: 0});
		send_child('{score: '0, visits: '0, prior: PRIOR_ONE, parent: '0, opp: 0, last: 0});
		send_child('{score: 36'd327680, visits: 1, prior: '0, parent: 12345, opp: 0, last: 1});
		send_child('{score: 36'd65536, visits: 1, prior: PRIOR_ONE, parent: '0, opp: 0, last: 0});
		send_child('{score: '0, visits: VISITS_TOP, prior: 1, parent: VISITS_TOP, opp: 0,
			last: 1});
	endtask

	task automatic test_ties();
		repeat (2) send_child('{score: 36'd32768, visits: 1, prior: 100, parent: 50, opp: 0,
			last: 0});
		send_child('{score: 36'd32768, visits: 1, prior: 100, parent: 50, opp: 0, last: 1});
		send_child('{score: 36'd10, visits: 1, prior: '0, parent: 7, opp: 0, last: 0});
		send_child('{score: 36'd20, visits: 1, prior: '0, parent: 7, opp: 0, last: 0});
		send_child('{score: 36'd20, visits: 1, prior: '0, parent: 7, opp: 0, last: 1});
	endtask

	task automatic test_opponent_turn();
		send_child('{score: 36'd196608, visits: 2, prior: '0, parent: 9, opp: 1, last: 0});
		send_child('{score: 36'd16384, visits: 1, prior: '0, parent: 9, opp: 1, last: 0});
		send_child('{score: 36'd65536, visits: 1, prior: '0, parent: 9, opp: 1, last: 0});
		send_child('{score: '0, visits: 1, prior: '0, parent: 9, opp: 1, last: 1});
	endtask

	task automatic test_weight_extremes();
		drain();
		write_weight('0);
		send_child('{score: 36'd100, visits: 3, prior: PRIOR_ONE, parent: VISITS_TOP, opp: 0,
			last: 0});
		send_child('{score: 36'd99, visits: 1, prior: PRIOR_ONE, parent: 3, opp: 0, last: 1});
		drain();
		write_weight('1);
		send_child('{score: 36'd1000, visits: '0, prior: PRIOR_ONE, parent: VISITS_TOP, opp: 1,
			last: 0});
		send_child('{score: SCORE_TOP, visits: 1, prior: PRIOR_ONE, parent: 1, opp: 0,
			last: 1});
		drain();
		write_weight(WEIGHT_RESET);
	endtask

	// more children than the index counts, so the position wraps
	task automatic test_long_node();
		child_t c;
		logic [VISITS_W-1:0] pv;
		pv = random_parent();
		for (int k = 0; k < 70; k++) begin
			c = random_child(pv, 1'b0);
			c.last = (k == 69);
			send_child(c);
		end
	endtask

	task automatic test_traffic(input logic [WEIGHT_W-1:0] w, input int idle,
		input int stall, input int unsigned budget);
		drain();
		write_weight(w);
		idle_pct = idle;
		stall_pct = stall;
		run_nodes(budget);
	endtask

	always @(posedge clk) begin
		pick_t want;
		if (out_valid && !out_stall) begin
			if (winner_q.size() == 0) begin
				note_fail($sformatf("unexpected result: index %0d value 0x%09h",
					best_index, best_value));
			end else begin
				want = winner_q.pop_front();
				if (want.index !== best_index)
					note_fail($sformatf("best_index: expected %0d, got %0d",
						want.index, best_index));
				if (want.value !== best_value)
					note_fail($sformatf("best_value: expected 0x%09h, got 0x%09h",
						want.value, best_value));
			end
		end
		// stall in bursts so that results back up into the next node
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if ($urandom_range(99) < stall_pct) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 39);
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_ties();
		test_opponent_turn();
		test_weight_extremes();
		test_long_node();
		test_traffic(16'($urandom), 0, 0, 210);
		test_traffic('1, 63, 0, 210);
		test_traffic('0, 0, 63, 210);
		test_traffic(16'($urandom_range(1, 8192)), 16, 16, 210);
		drain();
		if (winner_q.size() != 0) begin
			fail_cnt += winner_q.size();
			$display("%0d results never arrived", winner_q.size());
		end
		if (fail_cnt == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire
